@@ rtl/srx_pkg.sv @@
// shared types and constants of the serial frame receiver
`default_nettype none
package srx_pkg;

  localparam int COUNT_W    = 7;
  localparam int SUM_W      = 12;
  localparam int FIFO_DEPTH = 2;

  localparam logic [7:0] CH_START     = 8'h23;
  localparam logic [7:0] CH_END       = 8'h0D;
  localparam logic [7:0] CH_ADDR_BASE = 8'h61;
  localparam logic [7:0] CH_CK_BASE   = 8'h3D;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
  localparam logic [COUNT_W-1:0] MIN_COUNT   = 7'd6;
  localparam logic [COUNT_W-1:0] HEADER_LEN  = 7'd3;
  localparam logic [COUNT_W-1:0] OVERHEAD    = 7'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CKSUM = 2'd1,
    ST_SHORT = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // one finished frame as handed from the front to the back
  typedef struct packed {
    status_t              status;
    logic [7:0]           address;
    logic [7:0]           id;
    logic [COUNT_W-1:0]   plen;
    logic                 bank;
  } desc_t;

  // store bank handed back once its run has been delivered
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // byte taken as a signed char, as a residue mod 4096
  function automatic logic [SUM_W-1:0] signed_term(input logic [7:0] b);
    signed_term = {{(SUM_W-8){b[7]}}, b};
  endfunction

endpackage
`default_nettype wire

@@ rtl/serial_frame_receiver.sv @@
// top level of the serial frame receiver
//
// Input channel: one received byte per item on rx_byte, taken at a rising edge with
// push high and full low. Output channel: a queue, the oldest result sits on the
// result ports while empty is low and is taken on an edge with pop high.
// A good frame comes out as a run of its payload chars with status 0 and
// last_of_frame on the final char; a bad frame gives one error item.
// The front takes one byte per cycle while full is low. At carriage return the
// checked frame goes into a two entry descriptor queue; with the back idle it
// latches the descriptor from the queue and shows an error item, or fetches and
// latches the first char of a run from the store. The back reads the store one
// char at a time through fetch, latch and show, waiting in show for pop.
// The payload store has two banks of MAX_PAYLOAD+2 chars: the front fills one
// while the back drains the other, and full rises when the next bank to fill is
// still being drained or the queue holds two frames.
// A stalled receiver holds the current result steady and the front keeps taking
// bytes until those limits are hit. Reset clears the frame state, the queue and
// the output, and the block is ready in the cycle after reset falls.
`default_nettype none
module serial_frame_receiver #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] rx_byte,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      frame_address,
  output logic [7:0]      frame_id,
  output logic [7:0]      payload_char,
  output logic [1:0]      frame_status,
  output logic            last_of_frame
);
  import srx_pkg::*;

  localparam int STORE_DEPTH = MAX_PAYLOAD + 2;
  localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
  localparam int ADDR_W      = $clog2(RAM_DEPTH);

  desc_t              q_desc;
  desc_t              head;
  logic               q_wr;
  logic               q_rd;
  logic               q_full;
  logic               q_empty;
  release_t           rel;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;

  srx_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .q_wr    (q_wr),
    .q_desc  (q_desc),
    .q_full  (q_full),
    .rel     (rel),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  srx_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_desc (q_desc),
    .full    (q_full),
    .rd      (q_rd),
    .rd_desc (head),
    .empty   (q_empty)
  );

  srx_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srx_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .rel           (rel),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .empty         (empty),
    .pop           (pop),
    .frame_address (frame_address),
    .frame_id      (frame_id),
    .payload_char  (payload_char),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire

@@ rtl/srx_ram.sv @@
// generic single write port, single registered read port ram
`default_nettype none
module srx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 132,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/srx_fifo.sv @@
// two entry descriptor queue between front and back
`default_nettype none
module srx_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire srx_pkg::desc_t wr_desc,
  output logic               full,
  input  wire logic          rd,
  output srx_pkg::desc_t     rd_desc,
  output logic               empty
);
  import srx_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  desc_t                entry [FIFO_DEPTH];
  logic [PTR_W-1:0]     wptr;
  logic [PTR_W-1:0]     rptr;
  logic [PTR_W:0]       fill;

  assign full    = (fill == (PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign rd_desc = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) begin
        entry[wptr] <= wr_desc;
        wptr        <= (wptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd && !empty) begin
        rptr <= (rptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : rptr + PTR_W'(1);
      end
      unique case ({wr && !full, rd && !empty})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/srx_front.sv @@
// front end: parses bytes, stores payload, checks the frame at carriage return
`default_nettype none
module srx_front #(
  parameter int MAX_PAYLOAD = 64,
  localparam int STORE_DEPTH = MAX_PAYLOAD + 2,
  localparam int ADDR_W = $clog2(2 * STORE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [7:0]        rx_byte,
  output logic                   full,
  output logic                   q_wr,
  output srx_pkg::desc_t         q_desc,
  input  wire logic              q_full,
  input  wire srx_pkg::release_t rel,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [7:0]             wr_data
);
  import srx_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam logic [COUNT_W-1:0] STORE_END = COUNT_W'(STORE_DEPTH + 3);

  logic                in_frame;
  logic [COUNT_W-1:0]  byte_count;
  logic [7:0]          held_address;
  logic [7:0]          held_id;
  logic [SUM_W-1:0]    sum_base;
  logic [7:0]          tail1;
  logic [7:0]          tail2;
  logic                overflowed;
  logic                wbank;
  logic [1:0]          busy;

  logic                accept;
  logic                is_start;
  logic                is_end;
  logic                body;
  logic                storing;
  logic [COUNT_W-1:0]  count_m3;
  logic [IDX_W-1:0]    widx;
  logic [7:0]          exp1;
  logic [7:0]          exp2;
  logic [1:0]          busy_next;

  assign full     = q_full || busy[wbank];
  assign accept   = push && !full;
  assign is_start = (rx_byte == CH_START);
  assign is_end   = (rx_byte == CH_END);
  assign body     = accept && in_frame && !is_start && !is_end;
  assign count_m3 = byte_count - HEADER_LEN;
  assign widx     = count_m3[IDX_W-1:0];
  assign storing  = body && (byte_count >= HEADER_LEN) && (byte_count < STORE_END);

  assign wr_en   = storing;
  assign wr_data = rx_byte;
  assign wr_addr = wbank ? ADDR_W'(widx) + ADDR_W'(STORE_DEPTH) : ADDR_W'(widx);

  // the last two stored chars are the checksum, sum_base excludes them
  assign exp1 = CH_CK_BASE + {2'b00, sum_base[11:6]};
  assign exp2 = CH_CK_BASE + {2'b00, sum_base[5:0]};

  assign q_wr = accept && in_frame && !is_start && is_end;

  always_comb begin
    q_desc.address = held_address - CH_ADDR_BASE;
    q_desc.id      = held_id;
    q_desc.plen    = byte_count - OVERHEAD;
    q_desc.bank    = wbank;
    priority if (byte_count < MIN_COUNT) begin
      q_desc.status  = ST_SHORT;
      q_desc.address = '0;
      q_desc.id      = '0;
    end else if (overflowed) begin
      q_desc.status = ST_OVF;
    end else if (tail1 != exp1 || tail2 != exp2) begin
      q_desc.status = ST_CKSUM;
    end else begin
      q_desc.status = ST_OK;
    end
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (q_wr && q_desc.status == ST_OK) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= '0;
      overflowed   <= 1'b0;
      held_address <= '0;
      held_id      <= '0;
      wbank        <= 1'b0;
      busy         <= '0;
    end else begin
      busy <= busy_next;
      if (accept && is_start) begin
        in_frame     <= 1'b1;
        byte_count   <= 7'd1;
        held_address <= '0;
        held_id      <= '0;
        overflowed   <= 1'b0;
        sum_base     <= signed_term(rx_byte);
      end else if (q_wr) begin
        in_frame <= 1'b0;
        if (q_desc.status == ST_OK) begin
          wbank <= !wbank;
        end
      end else if (body) begin
        if (byte_count == 7'd1) begin
          held_address <= rx_byte;
          sum_base     <= sum_base + signed_term(rx_byte);
        end else if (byte_count == 7'd2) begin
          held_id  <= rx_byte;
          sum_base <= sum_base + signed_term(rx_byte);
        end else if (storing) begin
          // chars leave the checksum window into the sum
          if (byte_count >= OVERHEAD) begin
            sum_base <= sum_base + signed_term(tail1);
          end
          tail1 <= tail2;
          tail2 <= rx_byte;
        end else begin
          overflowed <= 1'b1;
        end
        if (byte_count < COUNT_MAX) begin
          byte_count <= byte_count + COUNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/srx_back.sv @@
// back end: turns frame descriptors into result items
`default_nettype none
module srx_back #(
  parameter int MAX_PAYLOAD = 64,
  localparam int STORE_DEPTH = MAX_PAYLOAD + 2,
  localparam int ADDR_W = $clog2(2 * STORE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srx_pkg::desc_t    head,
  input  wire logic              q_empty,
  output logic                   q_rd,
  output srx_pkg::release_t      rel,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             frame_address,
  output logic [7:0]             frame_id,
  output logic [7:0]             payload_char,
  output logic [1:0]             frame_status,
  output logic                   last_of_frame
);
  import srx_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_LATCH,
    B_SHOW
  } bstate_t;

  bstate_t           state;
  logic [IDX_W-1:0]  idx;
  logic              done;

  assign empty   = (state != B_SHOW);
  assign done    = (state == B_SHOW) && pop && last_of_frame;
  assign q_rd    = done;
  assign rel.valid = done && (head.status == ST_OK);
  assign rel.bank  = head.bank;
  assign rd_en   = (state == B_FETCH);
  assign rd_addr = head.bank ? ADDR_W'(idx) + ADDR_W'(STORE_DEPTH) : ADDR_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            frame_address <= head.address;
            frame_id      <= head.id;
            frame_status  <= head.status;
            idx           <= '0;
            if (head.status != ST_OK) begin
              payload_char  <= '0;
              last_of_frame <= 1'b1;
              state         <= B_SHOW;
            end else begin
              state <= B_FETCH;
            end
          end
        end
        B_FETCH: begin
          state <= B_LATCH;
        end
        B_LATCH: begin
          payload_char  <= rd_data;
          last_of_frame <= (COUNT_W'(idx) + COUNT_W'(1) == head.plen);
          state         <= B_SHOW;
        end
        B_SHOW: begin
          if (pop) begin
            if (last_of_frame) begin
              state <= B_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= B_FETCH;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/srx_checker.sv @@
// port level checks of the serial frame receiver and their bind
`default_nettype none
module srx_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic [7:0] rx_byte,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] frame_address,
  input wire logic [7:0] frame_id,
  input wire logic [7:0] payload_char,
  input wire logic [1:0] frame_status,
  input wire logic       last_of_frame
);
  import srx_pkg::*;

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // a waiting item stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(payload_char) && $stable(frame_status)
      && $stable(last_of_frame) && $stable(frame_address) && $stable(frame_id)))
    else $error("waiting item changed");

  // error items are single and carry no char
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status != ST_OK) |-> (last_of_frame && payload_char == 8'h00))
    else $error("error item not final or carries a char");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status == ST_SHORT) |-> (frame_address == 8'h00 && frame_id == 8'h00))
    else $error("too short item carries address or id");

  // the back needs a store read or a queue look-up before the next item
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("item shown in the cycle after a pop");

endmodule

bind serial_frame_receiver srx_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_serial_frame_receiver.sv @@
// self-checking testbench of the serial frame receiver, scoreboard class and stimulus
`timescale 1ns / 100ps
module tb_serial_frame_receiver;
  import srx_pkg::*;

  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 320;

  typedef enum int {
    K_GOOD, K_LONG, K_FULL, K_BADSUM, K_SHORT, K_OVERFLOW, K_NOISE, K_PARTIAL
  } frame_kind_t;

  // frame assembly and expected results, one received byte at a time
  class frame_scoreboard;
    typedef struct packed {
      logic [7:0]        address;
      logic [7:0]        id;
      logic [7:0]        ch;
      srx_pkg::status_t  status;
      logic              last;
    } frame_result_t;

    frame_result_t expected_q[$];
    bit            in_frame;
    logic [6:0]    byte_count;
    logic [7:0]    held_address;
    logic [7:0]    held_id;
    logic [11:0]   running_sum;
    bit            overflowed;
    // payload plus the two checksum chars
    logic [7:0]    store [0:65];
    int            errors;

    function new();
      in_frame     = 0;
      byte_count   = '0;
      held_address = '0;
      held_id      = '0;
      running_sum  = '0;
      overflowed   = 0;
      errors       = 0;
    endfunction

    static function logic [11:0] char_residue(logic [7:0] b);
      return {{4{b[7]}}, b};
    endfunction

    function void push_result(logic [7:0] a, logic [7:0] i, logic [7:0] c,
                              srx_pkg::status_t st, logic l);
      frame_result_t r;
      r.address = a;
      r.id      = i;
      r.ch      = c;
      r.status  = st;
      r.last    = l;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]  addr;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  e1;
      logic [7:0]  e2;
      logic [11:0] s;
      int          n;
      int          plen;
      int          idx;
      if (b == srx_pkg::CH_START) begin
        in_frame     = 1;
        byte_count   = 7'd1;
        held_address = '0;
        held_id      = '0;
        running_sum  = char_residue(b);
        overflowed   = 0;
        return;
      end
      if (!in_frame) return;
      if (b == srx_pkg::CH_END) begin
        in_frame = 0;
        addr = held_address - srx_pkg::CH_ADDR_BASE;
        if (byte_count <= 7'd5) begin
          push_result('0, '0, '0, srx_pkg::ST_SHORT, 1'b1);
        end else if (overflowed) begin
          push_result(addr, held_id, '0, srx_pkg::ST_OVF, 1'b1);
        end else begin
          n  = int'(byte_count) - 3;
          c1 = store[n-2];
          c2 = store[n-1];
          // strip the checksum chars back out of the running sum
          s  = running_sum - char_residue(c1) - char_residue(c2);
          e1 = srx_pkg::CH_CK_BASE + {2'b00, s[11:6]};
          e2 = srx_pkg::CH_CK_BASE + {2'b00, s[5:0]};
          plen = n - 2;
          if (c1 != e1 || c2 != e2) begin
            push_result(addr, held_id, '0, srx_pkg::ST_CKSUM, 1'b1);
          end else begin
            for (int k = 0; k < plen; k++)
              push_result(addr, held_id, store[k], srx_pkg::ST_OK, k == plen - 1);
          end
        end
        return;
      end
      running_sum = running_sum + char_residue(b);
      if (byte_count == 7'd1) begin
        held_address = b;
      end else if (byte_count == 7'd2) begin
        held_id = b;
      end else begin
        idx = int'(byte_count) - 3;
        if (idx < $size(store)) store[idx] = b;
        else overflowed = 1;
      end
      if (byte_count < srx_pkg::COUNT_MAX) byte_count = byte_count + 7'd1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_result(logic [7:0] a, logic [7:0] i, logic [7:0] c,
                               logic [1:0] st, logic l);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with none expected: address %0h id %0h char %0h status %0d",
               a, i, c, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a !== e.address) begin
        $error("frame_address: expected %0h, got %0h", e.address, a);
        errors++;
      end
      if (i !== e.id) begin
        $error("frame_id: expected %0h, got %0h", e.id, i);
        errors++;
      end
      if (c !== e.ch) begin
        $error("payload_char: expected %0h, got %0h", e.ch, c);
        errors++;
      end
      if (st !== 2'(e.status)) begin
        $error("frame_status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_of_frame: expected %0d, got %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] frame_address;
  logic [7:0] frame_id;
  logic [7:0] payload_char;
  logic [1:0] frame_status;
  logic       last_of_frame;

  frame_scoreboard sb;
  logic [7:0]      payload_buf[$];
  int              tx_run = 0;
  int              rx_run = 0;
  int              sent_count = 0;
  bit              random_phase = 0;

  serial_frame_receiver uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .rx_byte       (rx_byte),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .frame_address (frame_address),
    .frame_id      (frame_id),
    .payload_char  (payload_char),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short random gaps, now and then a run with none
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_START || b == CH_END);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_run);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    sent_count++;
    sb.note_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] addr_c, input logic [7:0] id_c,
                            input bit corrupt);
    logic [11:0] s;
    logic [7:0]  c1;
    logic [7:0]  c2;
    s = frame_scoreboard::char_residue(CH_START) + frame_scoreboard::char_residue(addr_c)
        + frame_scoreboard::char_residue(id_c);
    foreach (payload_buf[k]) s = s + frame_scoreboard::char_residue(payload_buf[k]);
    c1 = CH_CK_BASE + {2'b00, s[11:6]};
    c2 = CH_CK_BASE + {2'b00, s[5:0]};
    if (corrupt) begin
      if ($urandom_range(0, 1)) c1 = c1 ^ 8'h01;
      else c2 = c2 ^ (8'h01 << $urandom_range(0, 5));
    end
    send_byte(CH_START);
    send_byte(addr_c);
    send_byte(id_c);
    foreach (payload_buf[k]) send_byte(payload_buf[k]);
    send_byte(c1);
    send_byte(c2);
    send_byte(CH_END);
  endtask

  task automatic fill_payload(input int len);
    payload_buf.delete();
    repeat (len) payload_buf.push_back(plain_char());
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random pops, one long hold once random traffic starts
  initial begin : result_side
    int gap;
    bit held;
    held = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_gap(rx_run);
      if (random_phase && !held) begin
        held = 1;
        gap  = LONG_HOLD;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(frame_address, frame_id, payload_char, frame_status, last_of_frame);
    end
  end

  initial begin : stimulus
    frame_kind_t kind;
    int          pick;
    logic [7:0]  addr_c;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ignored outside a frame
    send_byte(CH_END);
    send_byte(8'hFF);
    // too short
    send_byte(CH_START);
    send_byte(CH_ADDR_BASE);
    send_byte(CH_END);
    payload_buf = '{8'h00, 8'hFF};
    send_frame(8'h00, 8'hFF, 0);
    // partial frame dropped by the next start char
    send_byte(CH_START);
    send_byte(8'h62);
    payload_buf = '{8'h80};
    send_frame(CH_ADDR_BASE, 8'h00, 0);
    payload_buf = '{8'h7F};
    send_frame(8'hFF, 8'h7F, 1);

    wait_drained();
    random_phase = 1;

    while (sent_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      kind = K_GOOD;
      else if (pick < 59) kind = K_LONG;
      else if (pick < 61) kind = K_FULL;
      else if (pick < 71) kind = K_BADSUM;
      else if (pick < 79) kind = K_SHORT;
      else if (pick < 81) kind = K_OVERFLOW;
      else if (pick < 90) kind = K_NOISE;
      else                kind = K_PARTIAL;
      addr_c = ($urandom_range(0, 3) != 0) ? CH_ADDR_BASE + 8'($urandom_range(0, 15))
                                           : plain_char();
      case (kind)
        K_GOOD: begin
          fill_payload($urandom_range(1, 6));
          send_frame(addr_c, plain_char(), 0);
        end
        K_LONG: begin
          fill_payload($urandom_range(7, 63));
          send_frame(addr_c, plain_char(), 0);
        end
        K_FULL: begin
          fill_payload(64);
          send_frame(addr_c, plain_char(), 0);
        end
        K_BADSUM: begin
          fill_payload($urandom_range(1, 8));
          send_frame(addr_c, plain_char(), 1);
        end
        K_SHORT: begin
          send_byte(CH_START);
          repeat ($urandom_range(0, 4)) send_byte(plain_char());
          send_byte(CH_END);
        end
        K_OVERFLOW: begin
          // occasionally long enough to saturate the byte count
          fill_payload(($urandom_range(0, 3) == 0) ? 130 : $urandom_range(65, 70));
          send_frame(addr_c, plain_char(), 0);
        end
        K_NOISE: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          send_byte(CH_START);
          repeat ($urandom_range(1, 8)) send_byte(plain_char());
        end
      endcase
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_serial_frame_receiver: PASS");
    else
      $display("tb_serial_frame_receiver: FAIL");
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("tb_serial_frame_receiver: FAIL");
    $finish;
  end

endmodule
